@@ sv/rrrs_pkg.sv @@
package rrrs_pkg;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 16;
  localparam int SPAN_W   = 17;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  typedef enum logic [CFG_AW-3:0] {
    REG_AREA_X        = 3'd0,
    REG_AREA_Y        = 3'd1,
    REG_AREA_WIDTH    = 3'd2,
    REG_AREA_HEIGHT   = 3'd3,
    REG_RADIUS_TL     = 3'd4,
    REG_RADIUS_TR     = 3'd5,
    REG_RADIUS_BR     = 3'd6,
    REG_RADIUS_BL     = 3'd7
  } cfg_reg_t;

endpackage

@@ sv/rounded_rect_row_span_unit.sv @@
// Channel  | Direction | Handshake          | Contents
// in       | input     | in_valid/in_ready  | row_offset, one word per row
// out      | output    | out_valid/out_ready| span_y, span_x_start, span_x_end, span_present
// cfg      | input     | psel/penable/pready| eight registers at byte address 4*i
//
// One word is accepted per cycle, unless every stage is full and the output is stalled.
// The pipeline depth comes from the square root, one result bit per stage for each corner.
// Reset is synchronous and active low; it clears the configuration and derived registers and all stage valids.
// A stall at the output fills empty stages first and never drops or repeats a word.
module rounded_rect_row_span_unit #(
  parameter int FRAC_BITS = 4,
  parameter int DIM_BITS  = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [DIM_BITS-1:0]                  in_row_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rrrs_pkg::SPAN_W-1:0]   out_span_y,
  output logic signed [rrrs_pkg::SPAN_W-1:0]   out_span_x_start,
  output logic signed [rrrs_pkg::SPAN_W-1:0]   out_span_x_end,
  output logic                                 out_span_present,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rrrs_pkg::CFG_AW-1:0]          paddr,
  input  logic [rrrs_pkg::CFG_DW-1:0]          pwdata,
  output logic [rrrs_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);

  localparam int RAD_W = rrrs_pkg::RADIUS_W + 1;
  localparam int QW    = 2 * RAD_W;
  localparam int SB    = RAD_W;
  localparam int SH    = FRAC_BITS + 1;
  localparam int CW    = (DIM_BITS + FRAC_BITS > RAD_W) ? DIM_BITS + FRAC_BITS : RAD_W;
  localparam int XW    = ((DIM_BITS > rrrs_pkg::COORD_W) ? DIM_BITS : rrrs_pkg::COORD_W) + 2;
  localparam int NST   = SB + 8;
  localparam int ST_A  = 0;
  localparam int ST_B  = 1;
  localparam int ST_C  = 2;
  localparam int ST_D  = 3;
  localparam int ST_E  = 4;
  localparam int ST_F  = 5;
  localparam int ST_G  = ST_F + SB + 1;
  localparam int ST_H  = ST_G + 1;
  localparam logic [RAD_W-1:0] HALF = RAD_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DIM_BITS-1:0]         row;
    logic                        ok;
    logic [1:0][RAD_W-1:0]       rad;
    logic [1:0]                  act;
  } meta_t;

  function automatic logic [RAD_W-1:0] clamp_rad(input logic [rrrs_pkg::RADIUS_W-1:0] reg_v,
                                                 input logic [CW-1:0] maxr);
    logic [CW-1:0] r2;
    r2 = CW'({reg_v, 1'b0});
    clamp_rad = (r2 < maxr) ? r2[RAD_W-1:0] : maxr[RAD_W-1:0];
  endfunction

  // Configuration registers.
  logic signed [rrrs_pkg::COORD_W-1:0]  cfg_x_r;
  logic signed [rrrs_pkg::COORD_W-1:0]  cfg_y_r;
  logic [DIM_BITS-1:0]                  cfg_w_r;
  logic [DIM_BITS-1:0]                  cfg_h_r;
  logic [3:0][rrrs_pkg::RADIUS_W-1:0]   cfg_rad_r;
  rrrs_pkg::cfg_reg_t                   cfg_idx;
  logic                                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = rrrs_pkg::cfg_reg_t'(paddr[rrrs_pkg::CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_x_r   <= '0;
      cfg_y_r   <= '0;
      cfg_w_r   <= '0;
      cfg_h_r   <= '0;
      cfg_rad_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rrrs_pkg::REG_AREA_X:      cfg_x_r      <= pwdata[rrrs_pkg::COORD_W-1:0];
        rrrs_pkg::REG_AREA_Y:      cfg_y_r      <= pwdata[rrrs_pkg::COORD_W-1:0];
        rrrs_pkg::REG_AREA_WIDTH:  cfg_w_r      <= pwdata[DIM_BITS-1:0];
        rrrs_pkg::REG_AREA_HEIGHT: cfg_h_r      <= pwdata[DIM_BITS-1:0];
        rrrs_pkg::REG_RADIUS_TL:   cfg_rad_r[0] <= pwdata[rrrs_pkg::RADIUS_W-1:0];
        rrrs_pkg::REG_RADIUS_TR:   cfg_rad_r[1] <= pwdata[rrrs_pkg::RADIUS_W-1:0];
        rrrs_pkg::REG_RADIUS_BR:   cfg_rad_r[2] <= pwdata[rrrs_pkg::RADIUS_W-1:0];
        rrrs_pkg::REG_RADIUS_BL:   cfg_rad_r[3] <= pwdata[rrrs_pkg::RADIUS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rrrs_pkg::REG_AREA_X:      prdata = rrrs_pkg::CFG_DW'(unsigned'(cfg_x_r));
      rrrs_pkg::REG_AREA_Y:      prdata = rrrs_pkg::CFG_DW'(unsigned'(cfg_y_r));
      rrrs_pkg::REG_AREA_WIDTH:  prdata = rrrs_pkg::CFG_DW'(cfg_w_r);
      rrrs_pkg::REG_AREA_HEIGHT: prdata = rrrs_pkg::CFG_DW'(cfg_h_r);
      rrrs_pkg::REG_RADIUS_TL:   prdata = rrrs_pkg::CFG_DW'(cfg_rad_r[0]);
      rrrs_pkg::REG_RADIUS_TR:   prdata = rrrs_pkg::CFG_DW'(cfg_rad_r[1]);
      rrrs_pkg::REG_RADIUS_BR:   prdata = rrrs_pkg::CFG_DW'(cfg_rad_r[2]);
      rrrs_pkg::REG_RADIUS_BL:   prdata = rrrs_pkg::CFG_DW'(cfg_rad_r[3]);
    endcase
  end

  // Values that follow from the configuration alone, settled in two register levels.
  logic [DIM_BITS-1:0]          min_side;
  logic [CW-1:0]                maxr;
  logic [3:0][RAD_W-1:0]        cl_nxt;
  logic [3:0][RAD_W-1:0]        cl_r;
  logic [RAD_W-1:0]             mx_top;
  logic [RAD_W-1:0]             mx_bot;
  logic [DIM_BITS-1:0]          top_nxt;
  logic [DIM_BITS-1:0]          top_r;
  logic [DIM_BITS-1:0]          bstart_nxt;
  logic [DIM_BITS-1:0]          bstart_r;

  always_comb begin
    min_side = (cfg_w_r < cfg_h_r) ? cfg_w_r : cfg_h_r;
    maxr     = CW'(min_side) << FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      cl_nxt[k] = clamp_rad(cfg_rad_r[k], maxr);
    end
    mx_top     = (cl_r[0] > cl_r[1]) ? cl_r[0] : cl_r[1];
    mx_bot     = (cl_r[3] > cl_r[2]) ? cl_r[3] : cl_r[2];
    top_nxt    = DIM_BITS'(mx_top >> SH);
    bstart_nxt = cfg_h_r - DIM_BITS'(mx_bot >> SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r     <= '0;
      top_r    <= '0;
      bstart_r <= '0;
    end else begin
      cl_r     <= cl_nxt;
      top_r    <= top_nxt;
      bstart_r <= bstart_nxt;
    end
  end

  // Elastic stage control: a stage loads when it is empty or its word moves on.
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      en[i] = out_ready | (|(~v_r & ({NST{1'b1}} << i)));
    end
  end

  assign in_ready  = en[ST_A];
  assign out_valid = v_r[ST_H];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage A: input register.
  logic [DIM_BITS-1:0] a_row_r;

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_row_r <= in_row_offset;
    end
  end

  // Stage B: row from the bottom edge and the area check.
  logic [DIM_BITS-1:0] b_row_r;
  logic [DIM_BITS-1:0] b_brow_r;
  logic                b_ok_r;

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      b_row_r  <= a_row_r;
      b_brow_r <= cfg_h_r - a_row_r - DIM_BITS'(1);
      b_ok_r   <= (cfg_w_r != '0) && (cfg_h_r != '0) && (a_row_r < cfg_h_r);
    end
  end

  // Stage C: pick the band and the corner radii.
  logic [DIM_BITS-1:0]   c_row_r;
  logic [DIM_BITS-1:0]   c_crow_r;
  logic                  c_ok_r;
  logic                  c_band_r;
  logic [1:0][RAD_W-1:0] c_rad_r;
  logic                  c_top;
  logic                  c_bot;

  always_comb begin
    c_top = b_row_r < top_r;
    c_bot = b_row_r >= bstart_r;
  end

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      c_row_r  <= b_row_r;
      c_ok_r   <= b_ok_r;
      c_band_r <= c_top || c_bot;
      if (c_top) begin
        c_crow_r   <= b_row_r;
        c_rad_r[0] <= cl_r[0];
        c_rad_r[1] <= cl_r[1];
      end else begin
        c_crow_r   <= b_brow_r;
        c_rad_r[0] <= cl_r[3];
        c_rad_r[1] <= cl_r[2];
      end
    end
  end

  // Stage D: per corner, whether the row is inside it and the vertical distance.
  meta_t                 d_meta_nxt;
  meta_t                 d_meta_r;
  logic [1:0][RAD_W-1:0] d_dy_nxt;
  logic [1:0][RAD_W-1:0] d_dy_r;
  logic [RAD_W-1:0]      crow_ext;

  always_comb begin
    crow_ext       = RAD_W'(c_crow_r);
    d_meta_nxt.row = c_row_r;
    d_meta_nxt.ok  = c_ok_r;
    d_meta_nxt.rad = c_rad_r;
    for (int l = 0; l < 2; l++) begin
      d_meta_nxt.act[l] = c_band_r && (crow_ext < (c_rad_r[l] >> SH));
      d_dy_nxt[l]       = c_rad_r[l] - (crow_ext << SH) - HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      d_meta_r <= d_meta_nxt;
      d_dy_r   <= d_dy_nxt;
    end
  end

  // Stage E: squares.
  meta_t              e_meta_r;
  logic [1:0][QW-1:0] e_rr_r;
  logic [1:0][QW-1:0] e_dd_r;

  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      e_meta_r <= d_meta_r;
      for (int l = 0; l < 2; l++) begin
        e_rr_r[l] <= QW'(d_meta_r.rad[l]) * QW'(d_meta_r.rad[l]);
        e_dd_r[l] <= QW'(d_dy_r[l]) * QW'(d_dy_r[l]);
      end
    end
  end

  // Stage F and the square root stages, one result bit per stage.
  meta_t              sq_meta_r [SB+1];
  logic [1:0][QW-1:0] sq_n_r    [SB+1];
  logic [1:0][QW-1:0] sq_res_r  [SB+1];
  logic [1:0][QW-1:0] sq_n_nxt  [SB+1];
  logic [1:0][QW-1:0] sq_res_nxt[SB+1];
  logic [1:0][QW-1:0] sq_t      [SB+1];

  always_comb begin
    sq_n_nxt[0]   = '0;
    sq_res_nxt[0] = '0;
    sq_t[0]       = '0;
    for (int j = 1; j <= SB; j++) begin
      for (int l = 0; l < 2; l++) begin
        sq_t[j][l] = sq_res_r[j-1][l] + (QW'(1) << (2 * (SB - j)));
        if (sq_n_r[j-1][l] >= sq_t[j][l]) begin
          sq_n_nxt[j][l]   = sq_n_r[j-1][l] - sq_t[j][l];
          sq_res_nxt[j][l] = (sq_res_r[j-1][l] >> 1) + (QW'(1) << (2 * (SB - j)));
        end else begin
          sq_n_nxt[j][l]   = sq_n_r[j-1][l];
          sq_res_nxt[j][l] = sq_res_r[j-1][l] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_F]) begin
      sq_meta_r[0] <= e_meta_r;
      sq_res_r[0]  <= '0;
      for (int l = 0; l < 2; l++) begin
        sq_n_r[0][l] <= e_rr_r[l] - e_dd_r[l];
      end
    end
    for (int j = 1; j <= SB; j++) begin
      if (en[ST_F + j]) begin
        sq_meta_r[j] <= sq_meta_r[j-1];
        sq_n_r[j]    <= sq_n_nxt[j];
        sq_res_r[j]  <= sq_res_nxt[j];
      end
    end
  end

  // Stage G: round the root half up and turn it into a whole pixel inset.
  logic [DIM_BITS-1:0]        g_row_r;
  logic                       g_ok_r;
  logic [1:0][DIM_BITS-1:0]   g_inset_r;
  logic [1:0][RAD_W:0]        g_s;
  logic [1:0][RAD_W:0]        g_num;
  logic [1:0][DIM_BITS-1:0]   g_inset_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      g_s[l]   = sq_res_r[SB][l][RAD_W:0]
                 + {{RAD_W{1'b0}}, (sq_n_r[SB][l] > sq_res_r[SB][l])};
      g_num[l] = {1'b0, sq_meta_r[SB].rad[l]} + {1'b0, HALF} - g_s[l];
      g_inset_nxt[l] = sq_meta_r[SB].act[l] ? DIM_BITS'(g_num[l] >> SH) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_G]) begin
      g_row_r   <= sq_meta_r[SB].row;
      g_ok_r    <= sq_meta_r[SB].ok;
      g_inset_r <= g_inset_nxt;
    end
  end

  // Stage H: coordinates and the output register.
  logic [XW-1:0]                 h_x0;
  logic [XW-1:0]                 h_x1;
  logic [XW-1:0]                 h_x2;
  logic [XW-1:0]                 h_y;
  logic                          h_pres;
  logic [rrrs_pkg::SPAN_W-1:0]   h_y_r;
  logic [rrrs_pkg::SPAN_W-1:0]   h_x1_r;
  logic [rrrs_pkg::SPAN_W-1:0]   h_x2_r;
  logic                          h_pres_r;

  always_comb begin
    h_x0   = XW'(cfg_x_r);
    h_x1   = h_x0 + XW'(g_inset_r[0]);
    h_x2   = h_x0 + XW'(cfg_w_r) - XW'(g_inset_r[1]);
    h_y    = XW'(cfg_y_r) + XW'(g_row_r);
    h_pres = g_ok_r && ((XW'(g_inset_r[0]) + XW'(g_inset_r[1])) < XW'(cfg_w_r));
  end

  always_ff @(posedge clk) begin
    if (en[ST_H]) begin
      h_pres_r <= h_pres;
      h_y_r    <= h_pres ? h_y[rrrs_pkg::SPAN_W-1:0] : '0;
      h_x1_r   <= h_pres ? h_x1[rrrs_pkg::SPAN_W-1:0] : '0;
      h_x2_r   <= h_pres ? h_x2[rrrs_pkg::SPAN_W-1:0] : '0;
    end
  end

  assign out_span_y       = h_y_r;
  assign out_span_x_start = h_x1_r;
  assign out_span_x_end   = h_x2_r;
  assign out_span_present = h_pres_r;

endmodule
